// ===== src/mvct_pkg.sv =====
package mvct_pkg;

   // Field widths of the configuration registers and of the channels.
   localparam int WORLD_W   = 24;
   localparam int ZOOM_W    = 11;
   localparam int ROT_W     = 16;
   localparam int VIEW_W    = 11;
   localparam int SIZE_W    = 8;
   localparam int PIXEL_W   = 16;

   // Fraction bits of the world coordinates.
   localparam int COORD_FRAC_BITS = 8;
   localparam int SINE_QUARTER_ENTRIES_DEF = 256;

   // Register port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_ROTATING_MODE = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ZOOM          = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ROTATION      = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_PIVOT_X       = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_PIVOT_Z       = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_VIEW_X        = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_VIEW_Y        = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_VIEW_SIZE     = 3'd7;

   localparam logic [ZOOM_W-1:0] ZOOM_MIN = 11'd64;
   localparam logic [ZOOM_W-1:0] ZOOM_MAX = 11'd1024;

   localparam logic [ZOOM_W-1:0] RESET_ZOOM      = 11'd256;
   localparam logic [VIEW_W-1:0] RESET_VIEW_X    = 11'd248;
   localparam logic [VIEW_W-1:0] RESET_VIEW_Y    = 11'd8;
   localparam logic [SIZE_W-1:0] RESET_VIEW_SIZE = 8'd64;

   // Datapath widths. Sine and cosine are Q15 with 1.0 held as 32768.
   localparam int TRIG_W    = 17;
   localparam int TRIG_FRAC = 15;
   localparam int ZOOM_FRAC = 8;
   localparam int DIFF_W    = WORLD_W + 1;
   localparam int DELTA_W   = 36;
   localparam int PROD_W    = DELTA_W + TRIG_W;
   localparam int PSUM_W    = PROD_W + 1;
   localparam int MAG_W     = PSUM_W;
   localparam int SCALED_W  = MAG_W + SIZE_W;

   // The map span of 2000 is 125 times 16, so the divisor is 125 times a power of two.
   localparam int MAP_HALF_SPAN = 1000;
   localparam int DEN_SHIFT     = COORD_FRAC_BITS + TRIG_FRAC + ZOOM_FRAC + 4;
   localparam int V_W           = SCALED_W - DEN_SHIFT;
   localparam int RECIP_W       = 30;
   localparam int RECIP_SHIFT   = 36;
   localparam logic [RECIP_W-1:0] RECIP_125 = 30'd549755814;
   localparam int QM_W          = V_W + RECIP_W - RECIP_SHIFT;

   localparam longint Q30_ONE     = 64'sd1073741824;
   localparam longint Q30_HALF_PI = 64'sd1686629713;

   typedef struct packed {
      logic                     rotating_mode;
      logic [ZOOM_W-1:0]        zoom;
      logic [ROT_W-1:0]         rotation;
      logic signed [WORLD_W-1:0] pivot_x;
      logic signed [WORLD_W-1:0] pivot_z;
      logic signed [VIEW_W-1:0] view_x;
      logic signed [VIEW_W-1:0] view_y;
      logic [SIZE_W-1:0]        view_size;
   } cfg_type;

   typedef struct packed {
      logic signed [WORLD_W-1:0] world_x;
      logic signed [WORLD_W-1:0] world_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [PIXEL_W-1:0] pixel_x;
      logic signed [PIXEL_W-1:0] pixel_y;
      logic                      in_view;
   } rsp_payload_type;

   // Sine of a Q30 angle in radians by an eleventh-order Taylor series in
   // Horner form, rounded to Q15 and capped at one.
   function automatic logic [TRIG_W-1:0] sine_q15(input longint angle);
      longint x2;
      longint t;
      longint s;
      longint q;
      x2 = (angle * angle) >>> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >>> 30) / 110;
      t  = Q30_ONE - ((x2 * t) >>> 30) / 72;
      t  = Q30_ONE - ((x2 * t) >>> 30) / 42;
      t  = Q30_ONE - ((x2 * t) >>> 30) / 20;
      t  = Q30_ONE - ((x2 * t) >>> 30) / 6;
      s  = (angle * t) >>> 30;
      if (s < 0) begin
         s = 0;
      end
      q = (s + 64'sd16384) >>> 15;
      if (q > 64'sd32768) begin
         q = 64'sd32768;
      end
      return TRIG_W'(q);
   endfunction

endpackage

// ===== src/mvct_csr.sv =====
module mvct_csr import mvct_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic                   write_en;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic [ZOOM_W-1:0]      wr_zoom;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite;
   assign reg_idx  = paddr[CSR_ADDR_W-1:2];
   assign wr_zoom  = pwdata[ZOOM_W-1:0];
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_idx)
            REG_ROTATING_MODE: cfg_in.rotating_mode = pwdata[0];
            REG_ZOOM: begin
               // A zoom outside its legal range is dropped and the old one kept.
               if (wr_zoom >= ZOOM_MIN && wr_zoom <= ZOOM_MAX) begin
                  cfg_in.zoom = wr_zoom;
               end
            end
            REG_ROTATION:  cfg_in.rotation  = pwdata[ROT_W-1:0];
            REG_PIVOT_X:   cfg_in.pivot_x   = pwdata[WORLD_W-1:0];
            REG_PIVOT_Z:   cfg_in.pivot_z   = pwdata[WORLD_W-1:0];
            REG_VIEW_X:    cfg_in.view_x    = pwdata[VIEW_W-1:0];
            REG_VIEW_Y:    cfg_in.view_y    = pwdata[VIEW_W-1:0];
            REG_VIEW_SIZE: cfg_in.view_size = pwdata[SIZE_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotating_mode <= 1'b0;
         cfg_ff.zoom          <= RESET_ZOOM;
         cfg_ff.rotation      <= '0;
         cfg_ff.pivot_x       <= '0;
         cfg_ff.pivot_z       <= '0;
         cfg_ff.view_x        <= RESET_VIEW_X;
         cfg_ff.view_y        <= RESET_VIEW_Y;
         cfg_ff.view_size     <= RESET_VIEW_SIZE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_ROTATING_MODE: prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.rotating_mode};
         REG_ZOOM:          prdata = {{(CSR_DATA_W-ZOOM_W){1'b0}}, cfg_ff.zoom};
         REG_ROTATION:      prdata = {{(CSR_DATA_W-ROT_W){1'b0}}, cfg_ff.rotation};
         REG_PIVOT_X:       prdata = {{(CSR_DATA_W-WORLD_W){1'b0}}, cfg_ff.pivot_x};
         REG_PIVOT_Z:       prdata = {{(CSR_DATA_W-WORLD_W){1'b0}}, cfg_ff.pivot_z};
         REG_VIEW_X:        prdata = {{(CSR_DATA_W-VIEW_W){1'b0}}, cfg_ff.view_x};
         REG_VIEW_Y:        prdata = {{(CSR_DATA_W-VIEW_W){1'b0}}, cfg_ff.view_y};
         REG_VIEW_SIZE:     prdata = {{(CSR_DATA_W-SIZE_W){1'b0}}, cfg_ff.view_size};
      endcase
   end

endmodule

// ===== src/mvct_sine.sv =====
module mvct_sine import mvct_pkg::*; #(
   parameter int SINE_QUARTER_ENTRIES = SINE_QUARTER_ENTRIES_DEF
) (
   input  logic [ROT_W-1:0]         rotation,
   output logic signed [TRIG_W-1:0] sin_val,
   output logic signed [TRIG_W-1:0] cos_val
);

   localparam int IDX_W  = $clog2(SINE_QUARTER_ENTRIES + 1);
   localparam int FRAC_W = ROT_W - 2;

   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;
   localparam logic [1:0] QUAD_FOURTH = 2'd3;

   logic [TRIG_W-1:0]        sine_rom [SINE_QUARTER_ENTRIES+1];
   logic [FRAC_W+IDX_W-1:0]  idx_prod;
   logic [IDX_W-1:0]         idx_lo;
   logic [IDX_W-1:0]         idx_hi;
   logic signed [TRIG_W-1:0] rom_a;
   logic signed [TRIG_W-1:0] rom_b;

   // Quarter-wave table, from 0 to 90 degrees inclusive, built at elaboration.
   for (genvar k = 0; k <= SINE_QUARTER_ENTRIES; k++) begin : g_rom
      localparam longint ANGLE = (longint'(k) * Q30_HALF_PI) / SINE_QUARTER_ENTRIES;
      assign sine_rom[k] = sine_q15(ANGLE);
   end

   // The position within the quadrant picks the lower neighboring entry.
   assign idx_prod = {{IDX_W{1'b0}}, rotation[FRAC_W-1:0]}
                   * (FRAC_W+IDX_W)'(SINE_QUARTER_ENTRIES);
   assign idx_lo   = idx_prod[FRAC_W+IDX_W-1:FRAC_W];
   assign idx_hi   = IDX_W'(SINE_QUARTER_ENTRIES) - idx_lo;
   assign rom_a    = $signed(sine_rom[idx_lo]);
   assign rom_b    = $signed(sine_rom[idx_hi]);

   always_comb begin
      unique case (rotation[ROT_W-1:FRAC_W])
         QUAD_FIRST: begin
            sin_val = rom_a;
            cos_val = rom_b;
         end
         QUAD_SECOND: begin
            sin_val = rom_b;
            cos_val = -rom_a;
         end
         QUAD_THIRD: begin
            sin_val = -rom_a;
            cos_val = -rom_b;
         end
         QUAD_FOURTH: begin
            sin_val = -rom_b;
            cos_val = rom_a;
         end
      endcase
   end

endmodule

// ===== src/map_view_coordinate_transform.sv =====
// Map view coordinate transform.
//
// A world point (world_x, world_z, signed Q15.8) enters on the req_ channel and
// one screen point leaves on the rsp_ channel: pixel_x and pixel_y saturated to
// 16 bits, and in_view set when the point lies inside the view square.
// A transaction happens on a channel at a rising edge where valid is high and
// stall is low. The view is set through the csr_ register port and must only be
// rewritten while no transaction is in flight.
//
// The datapath is a seven-stage pipeline: subtract and zoom, rotate, add the
// half span, take the magnitude, scale by the view size, divide by the span,
// then sign, offset and saturate. A result appears on rsp_ after its request
// has passed through every stage register in order; rsp_stall holds it there.
// One point can enter every cycle while req_stall is low.
// When rsp_stall holds the output, stages behind it keep filling bubbles until
// the pipeline is full; only then is req_stall raised. Nothing is dropped or
// repeated. Synchronous reset empties the pipeline and loads the register
// defaults (overview mode, zoom 1.0, view 64 pixels at 248, 8).
module map_view_coordinate_transform import mvct_pkg::*; #(
   parameter int SINE_QUARTER_ENTRIES = SINE_QUARTER_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int NUM_STAGES = 7;
   localparam int ST_ZOOM    = 0;
   localparam int ST_ROTATE  = 1;
   localparam int ST_OFFSET  = 2;
   localparam int ST_MAG     = 3;
   localparam int ST_SCALE   = 4;
   localparam int ST_DIVIDE  = 5;
   localparam int ST_OUT     = 6;

   localparam int PIX_SUM_W = (QM_W + 2 > PIXEL_W + 1) ? QM_W + 2 : PIXEL_W + 1;
   localparam logic signed [PSUM_W-1:0] MAP_HALF =
      PSUM_W'(longint'(MAP_HALF_SPAN) <<< (COORD_FRAC_BITS + TRIG_FRAC + ZOOM_FRAC));
   localparam logic signed [PIX_SUM_W-1:0] PIX_MAX = PIX_SUM_W'(32767);
   localparam logic signed [PIX_SUM_W-1:0] PIX_MIN = -PIX_SUM_W'(32768);
   localparam logic signed [PIXEL_W-1:0] PIXEL_HI = 16'sh7FFF;
   localparam logic signed [PIXEL_W-1:0] PIXEL_LO = 16'sh8000;

   cfg_type                   cfg;
   logic signed [TRIG_W-1:0]  sin_in;
   logic signed [TRIG_W-1:0]  cos_in;

   logic [NUM_STAGES-1:0]     valid_ff;
   logic [NUM_STAGES-1:0]     valid_in;
   logic [NUM_STAGES-1:0]     stage_en;

   mvct_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   mvct_sine #(
      .SINE_QUARTER_ENTRIES (SINE_QUARTER_ENTRIES)
   ) u_sine (
      .rotation (cfg.rotation),
      .sin_val  (sin_in),
      .cos_val  (cos_in)
   );

   // Pipeline control: a stage loads when it is empty or when the one after it moves.
   assign stage_en[ST_OUT] = !valid_ff[ST_OUT] || !rsp_stall;
   for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_enable
      assign stage_en[k] = !valid_ff[k] || stage_en[k+1];
   end

   assign valid_in[0] = stage_en[0] ? req_valid : valid_ff[0];
   for (genvar k = 1; k < NUM_STAGES; k++) begin : g_valid
      assign valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = valid_ff[ST_OUT];

   // Stage 1: take the point relative to the center and apply the zoom.
   logic signed [WORLD_W-1:0]       wx;
   logic signed [WORLD_W-1:0]       wz;
   logic signed [DIFF_W-1:0]        diff_x;
   logic signed [DIFF_W-1:0]        diff_z;
   logic signed [ZOOM_W:0]          zoom_s;
   logic signed [DIFF_W+ZOOM_W:0]   zprod_x;
   logic signed [DIFF_W+ZOOM_W:0]   zprod_z;
   logic signed [DELTA_W-1:0]       delta_x_in;
   logic signed [DELTA_W-1:0]       delta_z_in;
   logic signed [DELTA_W-1:0]       delta_x_ff;
   logic signed [DELTA_W-1:0]       delta_z_ff;
   logic signed [TRIG_W-1:0]        sin_ff;
   logic signed [TRIG_W-1:0]        cos_ff;
   logic                            rot_mode_ff;

   assign wx      = $signed(req_payload.world_x);
   assign wz      = $signed(req_payload.world_z);
   assign diff_x  = {wx[WORLD_W-1], wx} - {cfg.pivot_x[WORLD_W-1], cfg.pivot_x};
   assign diff_z  = {wz[WORLD_W-1], wz} - {cfg.pivot_z[WORLD_W-1], cfg.pivot_z};
   assign zoom_s  = $signed({1'b0, cfg.zoom});
   assign zprod_x = diff_x * zoom_s;
   assign zprod_z = diff_z * zoom_s;

   // In overview mode the raw world coordinate goes on unchanged.
   assign delta_x_in = cfg.rotating_mode ? zprod_x[DELTA_W-1:0]
                     : {{(DELTA_W-WORLD_W){wx[WORLD_W-1]}}, wx};
   assign delta_z_in = cfg.rotating_mode ? zprod_z[DELTA_W-1:0]
                     : {{(DELTA_W-WORLD_W){wz[WORLD_W-1]}}, wz};

   always_ff @(posedge clock) begin
      if (stage_en[ST_ZOOM]) begin
         delta_x_ff  <= delta_x_in;
         delta_z_ff  <= delta_z_in;
         sin_ff      <= sin_in;
         cos_ff      <= cos_in;
         rot_mode_ff <= cfg.rotating_mode;
      end
   end

   // Stage 2: the four rotation products. Overview mode shifts the coordinate
   // up by the same number of fraction bits so that both modes share the rest.
   logic signed [PROD_W-1:0] mul_xc;
   logic signed [PROD_W-1:0] mul_zs;
   logic signed [PROD_W-1:0] mul_xs;
   logic signed [PROD_W-1:0] mul_zc;
   logic [PROD_W-1:0]        shift_x;
   logic [PROD_W-1:0]        shift_z;
   logic signed [PROD_W-1:0] xc_in;
   logic signed [PROD_W-1:0] zs_in;
   logic signed [PROD_W-1:0] xs_in;
   logic signed [PROD_W-1:0] zc_in;
   logic signed [PROD_W-1:0] xc_ff;
   logic signed [PROD_W-1:0] zs_ff;
   logic signed [PROD_W-1:0] xs_ff;
   logic signed [PROD_W-1:0] zc_ff;

   assign mul_xc  = delta_x_ff * cos_ff;
   assign mul_zs  = delta_z_ff * sin_ff;
   assign mul_xs  = delta_x_ff * sin_ff;
   assign mul_zc  = delta_z_ff * cos_ff;
   assign shift_x = {{(PROD_W-DELTA_W){delta_x_ff[DELTA_W-1]}}, delta_x_ff}
                    << (TRIG_FRAC + ZOOM_FRAC);
   assign shift_z = {{(PROD_W-DELTA_W){delta_z_ff[DELTA_W-1]}}, delta_z_ff}
                    << (TRIG_FRAC + ZOOM_FRAC);
   assign xc_in   = rot_mode_ff ? mul_xc : shift_x;
   assign zs_in   = rot_mode_ff ? mul_zs : '0;
   assign xs_in   = rot_mode_ff ? mul_xs : '0;
   assign zc_in   = rot_mode_ff ? mul_zc : shift_z;

   always_ff @(posedge clock) begin
      if (stage_en[ST_ROTATE]) begin
         xc_ff <= xc_in;
         zs_ff <= zs_in;
         xs_ff <= xs_in;
         zc_ff <= zc_in;
      end
   end

   // Stage 3: combine the products and move the origin to the map corner.
   logic signed [PSUM_W-1:0] sum_x_in;
   logic signed [PSUM_W-1:0] sum_z_in;
   logic signed [PSUM_W-1:0] sum_x_ff;
   logic signed [PSUM_W-1:0] sum_z_ff;

   assign sum_x_in = {xc_ff[PROD_W-1], xc_ff} - {zs_ff[PROD_W-1], zs_ff} + MAP_HALF;
   assign sum_z_in = {xs_ff[PROD_W-1], xs_ff} + {zc_ff[PROD_W-1], zc_ff} + MAP_HALF;

   always_ff @(posedge clock) begin
      if (stage_en[ST_OFFSET]) begin
         sum_x_ff <= sum_x_in;
         sum_z_ff <= sum_z_in;
      end
   end

   // Stage 4: sign and magnitude, so the division truncates toward zero.
   logic [MAG_W-1:0] mag_x_in;
   logic [MAG_W-1:0] mag_z_in;
   logic [MAG_W-1:0] mag_x_ff;
   logic [MAG_W-1:0] mag_z_ff;
   logic             neg4_x_ff;
   logic             neg4_z_ff;

   assign mag_x_in = sum_x_ff[PSUM_W-1] ? (~sum_x_ff + 1'b1) : sum_x_ff;
   assign mag_z_in = sum_z_ff[PSUM_W-1] ? (~sum_z_ff + 1'b1) : sum_z_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_MAG]) begin
         mag_x_ff  <= mag_x_in;
         mag_z_ff  <= mag_z_in;
         neg4_x_ff <= sum_x_ff[PSUM_W-1];
         neg4_z_ff <= sum_z_ff[PSUM_W-1];
      end
   end

   // Stage 5: scale by the view size and divide by the power-of-two part of the span.
   logic [SCALED_W-1:0] scaled_x;
   logic [SCALED_W-1:0] scaled_z;
   logic [V_W-1:0]      v_x_ff;
   logic [V_W-1:0]      v_z_ff;
   logic                neg5_x_ff;
   logic                neg5_z_ff;

   assign scaled_x = mag_x_ff * cfg.view_size;
   assign scaled_z = mag_z_ff * cfg.view_size;

   always_ff @(posedge clock) begin
      if (stage_en[ST_SCALE]) begin
         v_x_ff    <= scaled_x[SCALED_W-1:DEN_SHIFT];
         v_z_ff    <= scaled_z[SCALED_W-1:DEN_SHIFT];
         neg5_x_ff <= neg4_x_ff;
         neg5_z_ff <= neg4_z_ff;
      end
   end

   // Stage 6: divide by 125 through a rounded-up reciprocal, exact over this range.
   logic [V_W+RECIP_W-1:0] recip_x;
   logic [V_W+RECIP_W-1:0] recip_z;
   logic [QM_W-1:0]        qm_x_ff;
   logic [QM_W-1:0]        qm_z_ff;
   logic                   neg6_x_ff;
   logic                   neg6_z_ff;

   assign recip_x = v_x_ff * RECIP_125;
   assign recip_z = v_z_ff * RECIP_125;

   always_ff @(posedge clock) begin
      if (stage_en[ST_DIVIDE]) begin
         qm_x_ff   <= recip_x[V_W+RECIP_W-1:RECIP_SHIFT];
         qm_z_ff   <= recip_z[V_W+RECIP_W-1:RECIP_SHIFT];
         neg6_x_ff <= neg5_x_ff;
         neg6_z_ff <= neg5_z_ff;
      end
   end

   // Stage 7: restore the sign, add the view origin and saturate.
   function automatic logic signed [PIXEL_W-1:0] saturate_pixel(
      input logic signed [PIX_SUM_W-1:0] value
   );
      logic signed [PIXEL_W-1:0] result;
      if (value > PIX_MAX) begin
         result = PIXEL_HI;
      end else if (value < PIX_MIN) begin
         result = PIXEL_LO;
      end else begin
         result = value[PIXEL_W-1:0];
      end
      return result;
   endfunction

   logic signed [QM_W:0]      qs_x;
   logic signed [QM_W:0]      qs_z;
   logic signed [PIX_SUM_W-1:0] pix_sum_x;
   logic signed [PIX_SUM_W-1:0] pix_sum_z;
   logic                      inside_x;
   logic                      inside_z;
   rsp_payload_type           rsp_in;
   rsp_payload_type           rsp_ff;

   assign qs_x      = neg6_x_ff ? -$signed({1'b0, qm_x_ff}) : $signed({1'b0, qm_x_ff});
   assign qs_z      = neg6_z_ff ? -$signed({1'b0, qm_z_ff}) : $signed({1'b0, qm_z_ff});
   assign pix_sum_x = PIX_SUM_W'(qs_x) + PIX_SUM_W'($signed(cfg.view_x));
   assign pix_sum_z = PIX_SUM_W'(qs_z) + PIX_SUM_W'($signed(cfg.view_y));

   // The offset from the view origin must lie in [0, view_size); a saturated
   // pixel is always far outside, so the offset alone decides.
   assign inside_x = (!neg6_x_ff || qm_x_ff == '0) && (qm_x_ff < QM_W'(cfg.view_size));
   assign inside_z = (!neg6_z_ff || qm_z_ff == '0) && (qm_z_ff < QM_W'(cfg.view_size));

   always_comb begin
      rsp_in.pixel_x = saturate_pixel(pix_sum_x);
      rsp_in.pixel_y = saturate_pixel(pix_sum_z);
      rsp_in.in_view = inside_x && inside_z;
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

   logic signed [VIEW_W+1:0] view_x_end;
   assign view_x_end = {cfg.view_x[VIEW_W-1], cfg.view_x[VIEW_W-1], cfg.view_x}
                     + {{(VIEW_W+2-SIZE_W){1'b0}}, cfg.view_size};

   // The input is held back only when every stage is occupied and the output waits.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff) && rsp_stall)
      else $error("request stalled while the pipeline has room");

   a_in_view_inside_square: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.in_view |->
         $signed(rsp_payload.pixel_x) >= $signed(cfg.view_x) &&
         $signed(rsp_payload.pixel_x) < view_x_end)
      else $error("in_view set for a pixel outside the view columns");

   a_overview_no_saturation: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !cfg.rotating_mode |->
         $signed(rsp_payload.pixel_x) != PIXEL_HI && $signed(rsp_payload.pixel_x) != PIXEL_LO &&
         $signed(rsp_payload.pixel_y) != PIXEL_HI && $signed(rsp_payload.pixel_y) != PIXEL_LO)
      else $error("overview pixel reached the saturation limit");

endmodule

// ===== sim/map_view_coordinate_transform_tb.sv =====
module map_view_coordinate_transform_tb;
   import mvct_pkg::*;

   localparam int QUARTER_N     = SINE_QUARTER_ENTRIES_DEF;
   localparam int ROT_FRAC      = COORD_FRAC_BITS + TRIG_FRAC + ZOOM_FRAC;
   localparam longint HALF_SPAN = 1000;
   localparam longint FULL_SPAN = 2000;
   localparam int PHASES        = 14;
   localparam int RANDOM_POINTS = 132;
   localparam int SETTLE_CYCLES = 12;
   localparam int LONG_HOLD     = 60;
   localparam int QUIET_LIMIT   = 2000;
   localparam int REPORT_LINES  = 50;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   req_payload_type pending_points[$];
   rsp_payload_type projected_points[$];
   rsp_payload_type oldest_projection;
   cfg_type         view_cfg;
   int              sine_lut [0:QUARTER_N];

   int   mismatch_count  = 0;
   int   quiet_cycles    = 0;
   int   send_idle_pct   = 0;
   int   recv_idle_pct   = 0;
   int   hold_left       = 0;
   logic long_hold_start = 1'b0;

   map_view_coordinate_transform DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Quarter-wave sine in Q15 from a truncating Taylor series evaluated in Q30.
   function automatic void fill_sine_table();
      longint x;
      longint x2;
      longint t;
      longint s;
      longint q;
      for (int k = 0; k <= QUARTER_N; k++) begin
         x  = (longint'(k) * Q30_HALF_PI) / QUARTER_N;
         x2 = (x * x) >>> 30;
         t  = Q30_ONE;
         t  = Q30_ONE - ((x2 * t) >>> 30) / 110;
         t  = Q30_ONE - ((x2 * t) >>> 30) / 72;
         t  = Q30_ONE - ((x2 * t) >>> 30) / 42;
         t  = Q30_ONE - ((x2 * t) >>> 30) / 20;
         t  = Q30_ONE - ((x2 * t) >>> 30) / 6;
         s  = (x * t) >>> 30;
         if (s < 0) begin
            s = 0;
         end
         q = (s + 16384) >>> 15;
         if (q > 32768) begin
            q = 32768;
         end
         sine_lut[k] = int'(q);
      end
   endfunction

   function automatic longint clamp16(input longint v);
      if (v > 32767) begin
         return 32767;
      end
      if (v < -32768) begin
         return -32768;
      end
      return v;
   endfunction

   function automatic rsp_payload_type project_point(input req_payload_type pt);
      longint wx, wz, cx, cz, span_px, vx, vy, zm;
      longint dx, dz, a, b, sn, cs, rx, rz, qx, qz, px, py;
      int idx;
      rsp_payload_type res;
      wx      = $signed(pt.world_x);
      wz      = $signed(pt.world_z);
      cx      = $signed(view_cfg.pivot_x);
      cz      = $signed(view_cfg.pivot_z);
      vx      = $signed(view_cfg.view_x);
      vy      = $signed(view_cfg.view_y);
      span_px = view_cfg.view_size;
      zm      = view_cfg.zoom;
      if (view_cfg.rotating_mode) begin
         dx  = (wx - cx) * zm;
         dz  = (wz - cz) * zm;
         idx = view_cfg.rotation[13:0];
         idx = (idx * QUARTER_N) >> 14;
         a   = sine_lut[idx];
         b   = sine_lut[QUARTER_N - idx];
         case (view_cfg.rotation[15:14])
            2'd0: begin sn = a;  cs = b;  end
            2'd1: begin sn = b;  cs = -a; end
            2'd2: begin sn = -a; cs = -b; end
            default: begin sn = -b; cs = a; end
         endcase
         rx = dx * cs - dz * sn;
         rz = dx * sn + dz * cs;
         qx = ((rx + (HALF_SPAN << ROT_FRAC)) * span_px) / (FULL_SPAN << ROT_FRAC);
         qz = ((rz + (HALF_SPAN << ROT_FRAC)) * span_px) / (FULL_SPAN << ROT_FRAC);
      end else begin
         qx = ((wx + (HALF_SPAN << COORD_FRAC_BITS)) * span_px)
              / (FULL_SPAN << COORD_FRAC_BITS);
         qz = ((wz + (HALF_SPAN << COORD_FRAC_BITS)) * span_px)
              / (FULL_SPAN << COORD_FRAC_BITS);
      end
      px = clamp16(vx + qx);
      py = clamp16(vy + qz);
      res.pixel_x = px[PIXEL_W-1:0];
      res.pixel_y = py[PIXEL_W-1:0];
      res.in_view = (px >= vx && px < vx + span_px && py >= vy && py < vy + span_px);
      return res;
   endfunction

   function automatic void apply_register(input logic [REG_IDX_W-1:0] idx,
                                          input logic [31:0] value);
      case (idx)
         REG_ROTATING_MODE: view_cfg.rotating_mode = value[0];
         REG_ZOOM: begin
            if (value[ZOOM_W-1:0] >= ZOOM_MIN && value[ZOOM_W-1:0] <= ZOOM_MAX) begin
               view_cfg.zoom = value[ZOOM_W-1:0];
            end
         end
         REG_ROTATION:  view_cfg.rotation  = value[ROT_W-1:0];
         REG_PIVOT_X:   view_cfg.pivot_x   = value[WORLD_W-1:0];
         REG_PIVOT_Z:   view_cfg.pivot_z   = value[WORLD_W-1:0];
         REG_VIEW_X:    view_cfg.view_x    = value[VIEW_W-1:0];
         REG_VIEW_Y:    view_cfg.view_y    = value[VIEW_W-1:0];
         REG_VIEW_SIZE: view_cfg.view_size = value[SIZE_W-1:0];
         default: ;
      endcase
   endfunction

   // Bits above the register width are filled with noise; the block must drop them.
   function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
      logic [31:0] mask;
      mask = (32'h1 << width) - 32'h1;
      return (value & mask) | ($urandom() & ~mask);
   endfunction

   function automatic logic [31:0] bad_zoom_value();
      case ($urandom_range(0, 3))
         0: return 32'd0;
         1: return 32'(ZOOM_MIN) - 32'd1;
         2: return 32'(ZOOM_MAX) + 32'd1;
         default: return 32'($urandom_range(1025, 2047));
      endcase
   endfunction

   function automatic logic [WORLD_W-1:0] rand_center();
      if ($urandom_range(0, 1)) begin
         return WORLD_W'($urandom_range(0, 512000)) - WORLD_W'(256000);
      end
      return WORLD_W'($urandom());
   endfunction

   // Coordinates are drawn from the whole range, the map bounds, the neighborhood
   // of the view center and a narrow band around the world origin.
   function automatic logic [WORLD_W-1:0] pick_coord(input logic [WORLD_W-1:0] centre);
      logic [WORLD_W-1:0] off;
      case ($urandom_range(0, 3))
         0: return WORLD_W'($urandom());
         1: return WORLD_W'($urandom_range(0, 512000)) - WORLD_W'(256000);
         2: begin
            off = WORLD_W'($urandom_range(0, 1 << $urandom_range(0, 20)));
            return $urandom_range(0, 1) ? centre + off : centre - off;
         end
         default: return WORLD_W'($urandom_range(0, 2000)) - WORLD_W'(1000);
      endcase
   endfunction

   task automatic queue_point(input int x, input int z);
      req_payload_type pt;
      pt.world_x = x[WORLD_W-1:0];
      pt.world_z = z[WORLD_W-1:0];
      pending_points.push_back(pt);
   endtask

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      apply_register(idx, value);
   endtask

   task automatic program_view(input logic mode, input logic [ZOOM_W-1:0] zm,
                               input logic [ROT_W-1:0] rot,
                               input logic [WORLD_W-1:0] cx, input logic [WORLD_W-1:0] cz,
                               input logic [VIEW_W-1:0] vx, input logic [VIEW_W-1:0] vy,
                               input logic [SIZE_W-1:0] sz);
      csr_write(REG_ROTATING_MODE, with_junk(32'(mode), 1));
      csr_write(REG_ZOOM,          with_junk(32'(zm), ZOOM_W));
      csr_write(REG_ROTATION,      with_junk(32'(rot), ROT_W));
      csr_write(REG_PIVOT_X,       with_junk(32'(cx), WORLD_W));
      csr_write(REG_PIVOT_Z,       with_junk(32'(cz), WORLD_W));
      csr_write(REG_VIEW_X,        with_junk(32'(vx), VIEW_W));
      csr_write(REG_VIEW_Y,        with_junk(32'(vy), VIEW_W));
      csr_write(REG_VIEW_SIZE,     with_junk(32'(sz), SIZE_W));
   endtask

   // Waits until every queued point has been sent and answered, then lets the
   // pipeline run empty. The check runs on the falling edge, after the driver
   // and the monitor have settled.
   task automatic settle_pipeline();
      while (pending_points.size() != 0 || req_valid || projected_points.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatch_count < REPORT_LINES) begin
         $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      end
      mismatch_count++;
   endtask

   // Point driver: a held transaction stays on the bus until the block takes it.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            projected_points.push_back(project_point(req_payload));
         end
         if (!req_valid || !req_stall) begin
            if (pending_points.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= pending_points.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (long_hold_start) begin
         rsp_stall <= 1'b1;
         hold_left <= LONG_HOLD;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Screen point monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (projected_points.size() == 0) begin
            report_mismatch("result with none outstanding, pixel_x",
                            $signed(rsp_payload.pixel_x), 0);
         end else begin
            oldest_projection = projected_points.pop_front();
            if (rsp_payload.pixel_x !== oldest_projection.pixel_x) begin
               report_mismatch("pixel_x", $signed(rsp_payload.pixel_x),
                               $signed(oldest_projection.pixel_x));
            end
            if (rsp_payload.pixel_y !== oldest_projection.pixel_y) begin
               report_mismatch("pixel_y", $signed(rsp_payload.pixel_y),
                               $signed(oldest_projection.pixel_y));
            end
            if (rsp_payload.in_view !== oldest_projection.in_view) begin
               report_mismatch("in_view", rsp_payload.in_view, oldest_projection.in_view);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      fill_sine_table();
      view_cfg.rotating_mode = 1'b0;
      view_cfg.zoom          = RESET_ZOOM;
      view_cfg.rotation      = '0;
      view_cfg.pivot_x       = '0;
      view_cfg.pivot_z       = '0;
      view_cfg.view_x        = RESET_VIEW_X;
      view_cfg.view_y        = RESET_VIEW_Y;
      view_cfg.view_size     = RESET_VIEW_SIZE;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase < 5) begin
            send_idle_pct <= 22;
            recv_idle_pct <= 75;
         end else if (phase < 10) begin
            send_idle_pct <= 75;
            recv_idle_pct <= 22;
         end else begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end

         case (phase)
            0: begin
               // Reset defaults: plain overview, map edges and truncation of
               // negative offsets toward zero.
               queue_point(0, 0);
               queue_point(-8388608, -8388608);
               queue_point(8388607, 8388607);
               queue_point(-8388608, 8388607);
               queue_point(-256000, -256000);
               queue_point(256000, 256000);
               queue_point(255999, -255999);
               queue_point(-256001, -264000);
               queue_point(-263999, 264000);
               queue_point(-1, 1);
               queue_point(24'h555555, 24'hAAAAAA);
               queue_point(24'hAAAAAA, 24'h555555);
            end
            1: begin
               program_view(1'b1, 11'd256, 16'h0000, 24'h0, 24'h0, 11'h0, 11'h0, 8'd255);
               queue_point(0, 0);
               queue_point(256000, 0);
               queue_point(0, -256000);
               queue_point(8388607, -8388608);
               queue_point(-8388608, 8388607);
               queue_point(1, -1);
            end
            2: program_view(1'b1, ZOOM_MIN, 16'h4000, rand_center(), rand_center(),
                            11'h400, 11'h3FF, 8'd1);
            3: begin
               // Largest zoom and span against the far corner of the world drive
               // the pixel past 16 bits.
               program_view(1'b1, ZOOM_MAX, 16'hFFFF, 24'h800000, 24'h7FFFFF,
                            11'h3FF, 11'h400, 8'd255);
               queue_point(8388607, -8388608);
               queue_point(-8388608, 8388607);
            end
            4: program_view(1'b0, 11'd256, 16'($urandom()), rand_center(), rand_center(),
                            11'($urandom()), 11'($urandom()), 8'd0);
            5: program_view(1'b1, 11'($urandom_range(64, 1024)), 16'h8000, rand_center(),
                            rand_center(), 11'($urandom()), 11'($urandom()), 8'd0);
            6: begin
               program_view(1'b1, 11'd512, 16'hC000, 24'h0, 24'h0, 11'd100, 11'd100, 8'd128);
               csr_write(REG_ZOOM, with_junk(bad_zoom_value(), ZOOM_W));
            end
            7: program_view(1'b0, ZOOM_MIN, 16'h3FFF, 24'h0, 24'h0, 11'h400, 11'h400, 8'd255);
            default: begin
               program_view($urandom_range(0, 3) != 0, 11'($urandom_range(64, 1024)),
                            16'($urandom()), rand_center(), rand_center(),
                            11'($urandom()), 11'($urandom()), 8'($urandom()));
               if ($urandom_range(0, 1)) begin
                  csr_write(REG_ZOOM, with_junk(bad_zoom_value(), ZOOM_W));
               end
            end
         endcase

         for (int n = 0; n < (phase == 0 ? 40 : RANDOM_POINTS); n++) begin
            queue_point(int'(pick_coord(view_cfg.pivot_x)), int'(pick_coord(view_cfg.pivot_z)));
         end

         // The receiver holds off while points keep coming, so the pipeline fills
         // and the block has to stall its input.
         if (phase == 11) begin
            @(posedge clock);
            long_hold_start <= 1'b1;
            @(posedge clock);
            long_hold_start <= 1'b0;
         end

         settle_pipeline();
      end

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
